/* design/psmbc_pkg.sv */
// Package for the per-source MAC byte counter: sizes, codes and beat types.
// Used by every module of the block but psmbc_ram; depends on nothing.
package psmbc_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int COUNTER_BITS  = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = IDX_W + 1;
  localparam int MAC_W         = 48;
  localparam int CTR_ROW_W     = 4 * COUNTER_BITS;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_ARP  = 16'h0806;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;

  localparam logic       REQ_ACCOUNT = 1'b0;
  localparam logic       REQ_READ    = 1'b1;

  localparam logic [1:0] ST_EXIST = 2'd0;
  localparam logic [1:0] ST_NEW   = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_MISS  = 2'd3;

  typedef enum logic [1:0] {
    PROTO_OTHER,
    PROTO_ARP,
    PROTO_IPV4,
    PROTO_IPV6
  } proto_e;

  typedef struct packed {
    logic        req_type;
    logic [47:0] src_mac;
    logic [15:0] ethertype;
    logic [15:0] frame_length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] total_bytes;
    logic [31:0] arp_bytes;
    logic [31:0] ipv4_bytes;
    logic [31:0] ipv6_bytes;
  } res_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    logic        is_read;
    logic [47:0] mac;
    proto_e      proto;
    logic [15:0] len;
  } qitem_t;

endpackage

/* design/psmbc_if.sv */
// Valid/ready channel interfaces for request and result beats.
// Depends on psmbc_pkg.
interface psmbc_req_if;
  logic               valid;
  logic               ready;
  psmbc_pkg::req_t    req;
  modport source (output valid, output req, input ready);
  modport sink   (input valid, input req, output ready);
endinterface

interface psmbc_res_if;
  logic               valid;
  logic               ready;
  psmbc_pkg::res_t    res;
  modport source (output valid, output res, input ready);
  modport sink   (input valid, input res, output ready);
endinterface

/* design/psmbc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the MAC and counter tables.
module psmbc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

/* design/psmbc_front.sv */
// Front end: accepts request beats, classifies the EtherType and queues items.
// Depends on psmbc_pkg and psmbc_if.
module psmbc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  psmbc_req_if.sink         req_i,
  output psmbc_pkg::qitem_t q_item_o,
  output logic              q_valid_o,
  input  logic              q_pop_i
);
  import psmbc_pkg::*;

  qitem_t     slot_q [2];
  logic       rd_ptr_q, rd_ptr_d, wr_ptr_q, wr_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  qitem_t     item;

  always_comb begin
    item.is_read = (req_i.req.req_type == REQ_READ);
    item.mac     = req_i.req.src_mac;
    item.len     = req_i.req.frame_length;
    case (req_i.req.ethertype)
      ETYPE_IPV4: item.proto = PROTO_IPV4;
      ETYPE_ARP:  item.proto = PROTO_ARP;
      ETYPE_IPV6: item.proto = PROTO_IPV6;
      default:    item.proto = PROTO_OTHER;
    endcase
  end

  assign req_i.ready = (count_q != 2'd2);
  assign push        = req_i.valid && req_i.ready;
  assign q_valid_o   = (count_q != 2'd0);
  assign q_item_o    = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push;
    rd_ptr_d = rd_ptr_q ^ q_pop_i;
    count_d  = count_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= 1'b0;
      wr_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= item;
    end
  end
endmodule

/* design/psmbc_back.sv */
// Back end: scans the MAC table, updates counters and drives result beats.
// Depends on psmbc_pkg, psmbc_if and psmbc_ram.
module psmbc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  psmbc_pkg::qitem_t q_item_i,
  input  logic              q_valid_i,
  output logic              q_pop_o,
  psmbc_res_if.source       res_o
);
  import psmbc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RDC  = 2'd2;
  localparam logic [1:0] S_UPD  = 2'd3;

  logic [1:0]       state_q, state_d;
  qitem_t           cur_q, cur_d;
  logic [CNT_W-1:0] idx_q, idx_d, used_q, used_d;
  logic             cmp_vld_q, cmp_vld_d, new_q, new_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d, slot_q, slot_d;
  logic             out_vld_q, out_vld_d;
  res_t             out_q, out_d;

  logic                 mac_we, ctr_we;
  logic [IDX_W-1:0]     mac_raddr;
  logic [MAC_W-1:0]     mac_rdata;
  logic [CTR_ROW_W-1:0] ctr_rdata, ctr_wdata, base;
  logic [COUNTER_BITS-1:0] tot, arp, ip4, ip6, len_x;

  psmbc_ram #(.WIDTH(MAC_W), .DEPTH(TABLE_ENTRIES)) u_mac_ram (
    .clk_i   (clk_i),
    .we_i    (mac_we),
    .waddr_i (used_q[IDX_W-1:0]),
    .wdata_i (cur_q.mac),
    .raddr_i (mac_raddr),
    .rdata_o (mac_rdata)
  );

  psmbc_ram #(.WIDTH(CTR_ROW_W), .DEPTH(TABLE_ENTRIES)) u_ctr_ram (
    .clk_i   (clk_i),
    .we_i    (ctr_we),
    .waddr_i (slot_q),
    .wdata_i (ctr_wdata),
    .raddr_i (slot_q),
    .rdata_o (ctr_rdata)
  );

  assign res_o.valid = out_vld_q;
  assign res_o.res   = out_q;
  assign mac_raddr   = idx_q[IDX_W-1:0];

  // Counter row layout, high to low: total, ARP, IPv4, IPv6.
  always_comb begin
    base  = new_q ? '0 : ctr_rdata;
    len_x = COUNTER_BITS'(cur_q.len);
    tot   = base[4*COUNTER_BITS-1:3*COUNTER_BITS] + len_x;
    arp   = base[3*COUNTER_BITS-1:2*COUNTER_BITS];
    ip4   = base[2*COUNTER_BITS-1:COUNTER_BITS];
    ip6   = base[COUNTER_BITS-1:0];
    if (!cur_q.is_read) begin
      case (cur_q.proto)
        PROTO_ARP:  arp = arp + len_x;
        PROTO_IPV4: ip4 = ip4 + len_x;
        PROTO_IPV6: ip6 = ip6 + len_x;
        default:    ;
      endcase
    end else begin
      tot = base[4*COUNTER_BITS-1:3*COUNTER_BITS];
    end
    ctr_wdata = {tot, arp, ip4, ip6};
  end

  always_comb begin
    state_d   = state_q;
    cur_d     = cur_q;
    idx_d     = idx_q;
    used_d    = used_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;
    slot_d    = slot_q;
    new_d     = new_q;
    out_vld_d = out_vld_q && !res_o.ready;
    out_d     = out_q;
    q_pop_o   = 1'b0;
    mac_we    = 1'b0;
    ctr_we    = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && !out_vld_q) begin
          q_pop_o   = 1'b1;
          cur_d     = q_item_i;
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          new_d     = 1'b0;
          state_d   = S_SCAN;
        end
      end
      S_SCAN: begin
        // One table read per cycle; the compare comes in the cycle after its read.
        if (cmp_vld_q && mac_rdata == cur_q.mac) begin
          slot_d  = cmp_idx_q;
          state_d = S_RDC;
        end else if (idx_q == used_q) begin
          if (cur_q.is_read) begin
            out_d     = '{status: ST_MISS, default: '0};
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else if (used_q[IDX_W]) begin
            out_d     = '{status: ST_FULL, default: '0};
            out_vld_d = 1'b1;
            state_d   = S_IDLE;
          end else begin
            mac_we  = 1'b1;
            slot_d  = used_q[IDX_W-1:0];
            used_d  = used_q + 1'b1;
            new_d   = 1'b1;
            state_d = S_UPD;
          end
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = idx_q[IDX_W-1:0];
          idx_d     = idx_q + 1'b1;
        end
      end
      S_RDC: begin
        state_d = S_UPD;
      end
      S_UPD: begin
        ctr_we    = !cur_q.is_read;
        out_d     = '{status: (new_q ? ST_NEW : ST_EXIST), total_bytes: tot[31:0],
                      arp_bytes: arp[31:0], ipv4_bytes: ip4[31:0],
                      ipv6_bytes: ip6[31:0]};
        out_vld_d = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      used_q    <= '0;
      out_vld_q <= 1'b0;
      cmp_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      out_vld_q <= out_vld_d;
      cmp_vld_q <= cmp_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    cmp_idx_q <= cmp_idx_d;
    slot_q    <= slot_d;
    new_q     <= new_d;
    out_q     <= out_d;
  end
endmodule

/* design/per_source_mac_protocol_byte_counter.sv */
// Per-source MAC byte counter: a scan of the used table entries, one per cycle.
// The time an item takes from leaving the queue to its result beat grows with N,
// the number of entries in use (at most 256), as the MAC table is scanned in order.
// The next item leaves the queue the cycle after the result beat is taken. A two-beat
// queue lets requests be taken while the back end works.
// Reset clears the fill count and the control state; the tables need no clearing.
module per_source_mac_protocol_byte_counter (
  input  logic        clk_i,
  input  logic        rst_ni,
  psmbc_req_if.sink   req_i,
  psmbc_res_if.source res_o
);
  import psmbc_pkg::*;

  qitem_t q_item;
  logic   q_valid, q_pop;

  psmbc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (req_i),
    .q_item_o  (q_item),
    .q_valid_o (q_valid),
    .q_pop_i   (q_pop)
  );

  psmbc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_item_i  (q_item),
    .q_valid_i (q_valid),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );
endmodule
